### design/fwcr_pkg.sv
// Shared types and constants for the FIFO with cursor removal.
`default_nettype none
package fwcr_pkg;

    localparam int DEPTH_DEF  = 16;
    localparam int DATA_WIDTH = 16;
    localparam int CAP_W      = 5;
    localparam int ACT_W      = 4;
    localparam int POS_W      = 5;
    localparam int OUT_W      = 64;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [ACT_W-1:0] {
        ACT_ENQUEUE = 4'd0,
        ACT_DEQUEUE = 4'd1,
        ACT_CLEAR   = 4'd2,
        ACT_BEGIN   = 4'd3,
        ACT_END     = 4'd4,
        ACT_NEXT    = 4'd5,
        ACT_PRIOR   = 4'd6,
        ACT_REMOVE  = 4'd7,
        ACT_QUERY   = 4'd8
    } action_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

endpackage
`default_nettype wire

### design/fwcr_cell.sv
// One storage cell of the shifting entry array.
`default_nettype none
module fwcr_cell #(
    parameter int DEPTH = fwcr_pkg::DEPTH_DEF,
    parameter int INDEX = 0
) (
    input  logic                              aclk,
    input  fwcr_pkg::cell_ctl_t               ctl,
    input  logic [$clog2(DEPTH)-1:0]          sel_idx,
    input  logic [fwcr_pkg::DATA_WIDTH-1:0]   wr_data,
    input  logic [fwcr_pkg::DATA_WIDTH-1:0]   nb_data,
    input  logic [$clog2(DEPTH)-1:0]          rd_idx,
    output logic [fwcr_pkg::DATA_WIDTH-1:0]   data_o,
    output logic [fwcr_pkg::DATA_WIDTH-1:0]   rd_o
);
    import fwcr_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    // A shift pulls the upper neighbor into every cell at or above the gap.
    always_comb begin
        data_next = data_reg;
        if (ctl.shift && (MY_IDX >= sel_idx)) begin
            data_next = nb_data;
        end else if (ctl.load && (MY_IDX == sel_idx)) begin
            data_next = wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_o = data_reg;
    assign rd_o   = (MY_IDX == rd_idx) ? data_reg : '0;

endmodule
`default_nettype wire

### design/fifo_with_cursor_removal_core.sv
// Top level of the bounded FIFO with a navigation cursor and removal at the cursor.
`default_nettype none
// Each input transaction carries one action in s_tuser and an item value in s_tdata, and
// yields exactly one result transaction that reports the queue after the action. The items
// sit in a row of cells that all shift in the same clock, so every action, including a
// removal from the middle, is applied in the cycle it is accepted; the result is formed from
// the updated cells and loaded into the output register once it is free. With m_tready held
// high a new transaction is accepted every cycle; otherwise the block holds at most one
// action whose result has not been registered yet and stalls s_tready until the output
// register frees up. The user must write the capacity through cfg_wr_en and cfg_wr_data only
// while the block is idle, which it does not enforce; 0 acts as 1, values above DEPTH as DEPTH.
module fifo_with_cursor_removal_core #(
    parameter int DEPTH = fwcr_pkg::DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [fwcr_pkg::CAP_W-1:0]    cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // data_in [15:0]
    input  logic [fwcr_pkg::DATA_WIDTH-1:0] s_tdata,
    // action [3:0]
    input  logic [fwcr_pkg::ACT_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status [0], removed_value [16:1], head_value [32:17], cursor_value [48:33],
    // item_count [53:49], cursor_position [58:54], is_empty [59], is_full [60], zeros above
    output logic [fwcr_pkg::OUT_W-1:0]    m_tdata
);
    import fwcr_pkg::*;

    localparam int IW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CURW = CW + 1;

    logic [CAP_W-1:0]       cap_reg;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic signed [CURW-1:0] cur_reg, cur_next;
    logic                   pend_reg;
    logic                   mvalid_reg;
    logic                   status_reg, status_next;
    logic [DATA_WIDTH-1:0]  removed_reg, removed_next;
    logic [OUT_W-1:0]       mdata_reg, mdata_next;

    logic                   accept, out_load;
    action_t                act;
    cell_ctl_t              ctl, cell_ctl;
    logic [IW-1:0]          sel_idx;
    logic [IW-1:0]          rd_idx;
    logic [CW-1:0]          cap_eff;
    logic                   full;
    logic signed [CURW-1:0] cnt_s, cnt_m1;
    logic                   cur_ok;
    logic [DATA_WIDTH-1:0]  rd_any;
    logic [DATA_WIDTH-1:0]  head_val, cur_val;
    logic [31:0]            cnt32;
    logic signed [31:0]     cur32;

    logic [DATA_WIDTH-1:0]  cell_data [DEPTH];
    logic [DATA_WIDTH-1:0]  cell_rd   [DEPTH];

    assign out_load = pend_reg && (!mvalid_reg || m_tready);
    assign s_tready = !pend_reg || out_load;
    assign accept   = s_tvalid && s_tready;
    assign act      = action_t'(s_tuser);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CW'(1);
        end else if (int'(cap_reg) > DEPTH) begin
            cap_eff = CW'(DEPTH);
        end else begin
            cap_eff = CW'(cap_reg);
        end
    end

    assign full   = (cnt_reg >= cap_eff);
    assign cnt_s  = signed'({1'b0, cnt_reg});
    assign cnt_m1 = cnt_s - CURW'(1);
    assign cur_ok = (cur_reg >= 0) && (cur_reg < cnt_s);
    assign rd_idx = cur_reg[IW-1:0];

    always_comb begin
        rd_any = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_any = rd_any | cell_rd[i];
        end
    end

    always_comb begin
        cnt_next     = cnt_reg;
        cur_next     = cur_reg;
        status_next  = 1'b0;
        removed_next = '0;
        ctl          = '0;
        sel_idx      = cnt_reg[IW-1:0];
        case (act)
            ACT_ENQUEUE: begin
                if (full) begin
                    status_next = 1'b1;
                end else begin
                    ctl.load = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                    cur_next = cnt_s;
                end
            end
            ACT_DEQUEUE: begin
                if (cnt_reg == '0) begin
                    status_next = 1'b1;
                end else begin
                    removed_next = cell_data[0];
                    ctl.shift    = 1'b1;
                    sel_idx      = '0;
                    cnt_next     = cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        cur_next = '1;
                    end else if (cur_reg >= 0) begin
                        cur_next = cur_reg - CURW'(1);
                    end
                end
            end
            ACT_CLEAR: begin
                cnt_next = '0;
                cur_next = '1;
            end
            ACT_BEGIN: begin
                if (cnt_reg == '0) begin
                    status_next = 1'b1;
                end else begin
                    cur_next = '0;
                end
            end
            ACT_END: begin
                if (cnt_reg == '0) begin
                    status_next = 1'b1;
                end else begin
                    cur_next = cnt_m1;
                end
            end
            ACT_NEXT: begin
                if (cur_reg < cnt_m1) begin
                    cur_next = cur_reg + CURW'(1);
                end else begin
                    status_next = 1'b1;
                end
            end
            ACT_PRIOR: begin
                if (cur_reg > 0) begin
                    cur_next = cur_reg - CURW'(1);
                end else begin
                    status_next = 1'b1;
                end
            end
            ACT_REMOVE: begin
                if ((cnt_reg == '0) || !cur_ok) begin
                    status_next = 1'b1;
                end else begin
                    removed_next = rd_any;
                    ctl.shift    = 1'b1;
                    sel_idx      = cur_reg[IW-1:0];
                    cnt_next     = cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        cur_next = '1;
                    end else if (cur_reg != 0) begin
                        cur_next = cur_reg - CURW'(1);
                    end
                end
            end
            ACT_QUERY: begin
                status_next = 1'b0;
            end
            default: begin
                status_next = 1'b1;
            end
        endcase
    end

    assign cell_ctl = accept ? ctl : '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] nb;
        if (g == DEPTH - 1) begin : g_last
            assign nb = cell_data[g];
        end else begin : g_mid
            assign nb = cell_data[g+1];
        end
        fwcr_cell #(
            .DEPTH (DEPTH),
            .INDEX (g)
        ) u_cell (
            .aclk    (aclk),
            .ctl     (cell_ctl),
            .sel_idx (sel_idx),
            .wr_data (s_tdata),
            .nb_data (nb),
            .rd_idx  (rd_idx),
            .data_o  (cell_data[g]),
            .rd_o    (cell_rd[g])
        );
    end

    assign head_val = (cnt_reg != '0) ? cell_data[0] : '0;
    assign cur_val  = cur_ok ? rd_any : '0;
    assign cnt32    = 32'(cnt_reg);
    assign cur32    = 32'(cur_reg);

    always_comb begin
        mdata_next = {3'b000, full, (cnt_reg == '0), cur32[POS_W-1:0], cnt32[POS_W-1:0],
                      cur_val, head_val, removed_reg, status_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg    <= CAP_RESET;
            cnt_reg    <= '0;
            cur_reg    <= '1;
            pend_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (accept) begin
                cnt_reg <= cnt_next;
                cur_reg <= cur_next;
            end
            if (accept) begin
                pend_reg <= 1'b1;
            end else if (out_load) begin
                pend_reg <= 1'b0;
            end
            if (out_load) begin
                mvalid_reg <= 1'b1;
            end else if (m_tready) begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
        end
        if (out_load) begin
            mdata_reg <= mdata_next;
        end
    end

endmodule
`default_nettype wire

### design/fwcr_checker.sv
// Port-level assertions for the FIFO with cursor removal, bound to the top level.
`default_nettype none
module fwcr_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [fwcr_pkg::OUT_W-1:0]  m_tdata
);
    import fwcr_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Result transaction changed while stalled.");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[59] == (m_tdata[53:49] == 5'd0)))
        else $error("Empty flag disagrees with the item count.");

    a_empty_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[59] |->
            (m_tdata[58:54] == 5'h1f) && (m_tdata[48:33] == 16'd0) && (m_tdata[32:17] == 16'd0))
        else $error("Empty queue reports a cursor or an item value.");

    a_refused_removed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> (m_tdata[16:1] == 16'd0))
        else $error("Refused action reports a removed value.");

endmodule

bind fifo_with_cursor_removal_core fwcr_checker u_fwcr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
